@@ rtl/core/nonpreemptive_priority_scheduler_unit_assert.svh @@
// assertion macros for the scheduler checker
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define NPSCH_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed: same-cycle implication");

// next-cycle implication, sampled on clock, off during reset
`define NPSCH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed: next-cycle implication");

`endif

@@ rtl/core/npsch_pkg.sv @@
// shared types and constants of the priority scheduler
package npsch_pkg;

   localparam int TIME_W = 22;
   localparam int ARR_W  = 16;
   localparam int LEN_W  = 16;
   localparam int ID_W   = 8;
   localparam int PRI_W  = 8;
   localparam int IDX_W  = 6;   // covers the largest supported table

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [ARR_W-1:0] arr;
      logic [LEN_W-1:0] len;
      logic [PRI_W-1:0] pri;
   } entry_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic              load;
      logic [IDX_W-1:0]  load_idx;
      logic              mark;
      logic [IDX_W-1:0]  mark_idx;
      logic              clear;
      logic [TIME_W-1:0] now_time;
   } ctrl_type;

   // running candidate handed from cell to cell during a scan pass
   typedef struct packed {
      logic              live;
      logic              found;
      logic [PRI_W-1:0]  pri;
      logic [IDX_W-1:0]  idx;
      logic [ID_W-1:0]   id;
      logic [ARR_W-1:0]  arr;
      logic [LEN_W-1:0]  len;
      logic              seen;
      logic [ARR_W-1:0]  min_arr;
   } cand_type;

endpackage

@@ rtl/core/nonpreemptive_priority_scheduler_unit.sv @@
// top level of the non-preemptive priority scheduler
// load: one request per cycle while idle, busy stays low until the request marked last
// schedule: each pick is one scan pass through the cell chain,
//   plus one more pass whenever time has to jump to the next arrival
// n processes take n to 2n passes, each result registered at the end of its pass;
//   results cannot be held off; sync active-high reset empties the table
module nonpreemptive_priority_scheduler_unit #(
   parameter int MAX_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_proc_id,
   input  logic [15:0] req_arrival,
   input  logic [15:0] req_burst,
   input  logic [7:0]  req_prio,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_id,
   output logic [21:0] rsp_start_time,
   output logic [21:0] rsp_completion,
   output logic [21:0] rsp_turnaround,
   output logic [21:0] rsp_waiting,
   output logic        rsp_final_res
);

   // fill count must be able to hold MAX_PROCS itself
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TW    = npsch_pkg::TIME_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_INJECT = 2'd1;   // launch a scan token into cell 0
   localparam logic [1:0] ST_WAIT   = 2'd2;   // token travels down the chain

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] load_count_ff, load_count_in;
   logic [CNT_W-1:0] finished_ff, finished_in;
   logic [CNT_W-1:0] finished_inc;
   logic [TW-1:0]    now_ff, now_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_id_ff, rsp_id_in;
   logic [TW-1:0]    rsp_start_ff, rsp_start_in;
   logic [TW-1:0]    rsp_fin_ff, rsp_fin_in;
   logic [TW-1:0]    rsp_ta_ff, rsp_ta_in;
   logic [TW-1:0]    rsp_wt_ff, rsp_wt_in;
   logic             rsp_final_ff, rsp_final_in;

   npsch_pkg::ctrl_type  ctrl;
   npsch_pkg::entry_type load_data;
   npsch_pkg::cand_type  chain [MAX_PROCS+1];
   npsch_pkg::cand_type  tail;

   logic          accept;
   logic [TW-1:0] len_ext, arr_ext;
   logic [TW-1:0] pick_fin, pick_wait, pick_ta;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign load_data.id  = req_proc_id;
   assign load_data.arr = req_arrival;
   assign load_data.len = req_burst;
   assign load_data.pri = req_prio;

   // the head of the chain gets an empty candidate, live only on launch
   always_comb begin
      chain[0]      = '0;
      chain[0].live = (state_ff == ST_INJECT);
   end

   genvar g;
   generate
      for (g = 0; g < MAX_PROCS; g++) begin : g_cell
         npsch_cell #(
            .CELL_IDX(g)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .load_data (load_data),
            .cand_prev (chain[g]),
            .cand_next (chain[g+1])
         );
      end
   endgenerate

   assign tail = chain[MAX_PROCS];

   // wait = start - arrival, turnaround = wait + burst, all modulo the time width
   assign len_ext   = {{(TW-npsch_pkg::LEN_W){1'b0}}, tail.len};
   assign arr_ext   = {{(TW-npsch_pkg::ARR_W){1'b0}}, tail.arr};
   assign pick_fin  = now_ff + len_ext;
   assign pick_wait = now_ff - arr_ext;
   assign pick_ta   = pick_wait + len_ext;

   assign finished_inc = finished_ff + CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      finished_in   = finished_ff;
      now_in        = now_ff;

      rsp_valid_in = 1'b0;
      rsp_id_in    = tail.id;
      rsp_start_in = now_ff;
      rsp_fin_in   = pick_fin;
      rsp_ta_in    = pick_ta;
      rsp_wt_in    = pick_wait;
      rsp_final_in = (finished_inc == load_count_ff);

      ctrl          = '0;
      ctrl.now_time = now_ff;
      ctrl.load_idx = npsch_pkg::IDX_W'(load_count_ff);
      ctrl.mark_idx = tail.idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // a full table drops the request but still honors last
               if (load_count_ff < CNT_W'(MAX_PROCS)) begin
                  ctrl.load     = 1'b1;
                  load_count_in = load_count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  state_in = ST_INJECT;
               end
            end
         end
         ST_INJECT: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (tail.live) begin
               state_in = ST_INJECT;
               if (tail.found) begin
                  rsp_valid_in = 1'b1;
                  ctrl.mark    = 1'b1;
                  now_in       = pick_fin;
                  finished_in  = finished_inc;
                  if (finished_inc == load_count_ff) begin
                     // batch done: empty the table for the next one
                     ctrl.clear    = 1'b1;
                     state_in      = ST_IDLE;
                     load_count_in = '0;
                     finished_in   = '0;
                     now_in        = '0;
                  end
               end else begin
                  // nothing arrived yet: jump to the earliest pending arrival
                  now_in = {{(TW-npsch_pkg::ARR_W){1'b0}}, tail.min_arr};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         finished_ff   <= '0;
         now_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         finished_ff   <= finished_in;
         now_ff        <= now_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a result
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_id_ff    <= rsp_id_in;
         rsp_start_ff <= rsp_start_in;
         rsp_fin_ff   <= rsp_fin_in;
         rsp_ta_ff    <= rsp_ta_in;
         rsp_wt_ff    <= rsp_wt_in;
         rsp_final_ff <= rsp_final_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_start_time = rsp_start_ff;
   assign rsp_completion = rsp_fin_ff;
   assign rsp_turnaround = rsp_ta_ff;
   assign rsp_waiting    = rsp_wt_ff;
   assign rsp_final_res  = rsp_final_ff;

endmodule

@@ rtl/core/npsch_cell.sv @@
// one table slot of the scheduler chain with its scan stage
module npsch_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  npsch_pkg::ctrl_type ctrl,
   input  npsch_pkg::entry_type load_data,
   input  npsch_pkg::cand_type cand_prev,
   output npsch_pkg::cand_type cand_next
);

   localparam logic [npsch_pkg::IDX_W-1:0] MY_IDX = npsch_pkg::IDX_W'(CELL_IDX);

   npsch_pkg::entry_type entry_ff;
   logic                 loaded_ff, loaded_in;
   logic                 done_ff, done_in;
   npsch_pkg::cand_type  cand_ff, cand_in;
   logic                 pending;
   logic                 arrived;

   assign pending = loaded_ff && !done_ff;
   assign arrived = pending &&
                    ({{(npsch_pkg::TIME_W-npsch_pkg::ARR_W){1'b0}}, entry_ff.arr}
                     <= ctrl.now_time);

   always_comb begin
      loaded_in = loaded_ff;
      done_in   = done_ff;
      if (ctrl.clear) begin
         loaded_in = 1'b0;
         done_in   = 1'b0;
      end else if (ctrl.load && ctrl.load_idx == MY_IDX) begin
         loaded_in = 1'b1;
         done_in   = 1'b0;
      end else if (ctrl.mark && ctrl.mark_idx == MY_IDX) begin
         done_in = 1'b1;
      end
   end

   // strict compare keeps the earlier slot on equal priority
   always_comb begin
      cand_in = cand_prev;
      if (arrived && (!cand_prev.found || entry_ff.pri < cand_prev.pri)) begin
         cand_in.found = 1'b1;
         cand_in.pri   = entry_ff.pri;
         cand_in.idx   = MY_IDX;
         cand_in.id    = entry_ff.id;
         cand_in.arr   = entry_ff.arr;
         cand_in.len   = entry_ff.len;
      end
      if (pending && (!cand_prev.seen || entry_ff.arr < cand_prev.min_arr)) begin
         cand_in.seen    = 1'b1;
         cand_in.min_arr = entry_ff.arr;
      end
   end

   // only the flags and the token marker need a reset, the payload follows the token
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= 1'b0;
         done_ff      <= 1'b0;
         cand_ff.live <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         done_ff      <= done_in;
         cand_ff.live <= cand_in.live;
      end
      if (ctrl.load && ctrl.load_idx == MY_IDX) begin
         entry_ff <= load_data;
      end
      cand_ff.found   <= cand_in.found;
      cand_ff.pri     <= cand_in.pri;
      cand_ff.idx     <= cand_in.idx;
      cand_ff.id      <= cand_in.id;
      cand_ff.arr     <= cand_in.arr;
      cand_ff.len     <= cand_in.len;
      cand_ff.seen    <= cand_in.seen;
      cand_ff.min_arr <= cand_in.min_arr;
   end

   assign cand_next = cand_ff;

endmodule

@@ rtl/core/npsch_checker.sv @@
// port-level checker for the priority scheduler, bound to the top level
`include "nonpreemptive_priority_scheduler_unit_assert.svh"

module npsch_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last,
   input logic        rsp_valid,
   input logic [21:0] rsp_start_time,
   input logic [21:0] rsp_completion,
   input logic [21:0] rsp_turnaround,
   input logic [21:0] rsp_waiting,
   input logic        rsp_final_res
);

   // results other than the last one come while the schedule is still running
   `NPSCH_ASSERT_IMPLY(a_mid_result_busy, rsp_valid && !rsp_final_res, busy)
   // the final result leaves the block ready for a new batch
   `NPSCH_ASSERT_IMPLY(a_final_result_idle, rsp_valid && rsp_final_res, !busy)
   // each pick needs a full scan, so strobes never come back to back
   `NPSCH_ASSERT_NEXT(a_no_back_to_back, rsp_valid, !rsp_valid)
   // a plain load request produces nothing
   `NPSCH_ASSERT_NEXT(a_load_silent, start && !busy && !req_last, !rsp_valid)
   // run length seen two ways must agree
   `NPSCH_ASSERT_IMPLY(a_burst_consistent, rsp_valid,
      22'(rsp_completion - rsp_start_time) == 22'(rsp_turnaround - rsp_waiting))

endmodule

bind nonpreemptive_priority_scheduler_unit npsch_checker u_npsch_checker (.*);
